// File: src/two_wire_sensor_bus_master_assert.svh
// -----------------------------------------------------------------------------
// Two-wire sensor bus master assertion macros
// Shared property wrappers for the checker of the two-wire sensor bus master.
// -----------------------------------------------------------------------------
`ifndef TWO_WIRE_SENSOR_BUS_MASTER_ASSERT_SVH
`define TWO_WIRE_SENSOR_BUS_MASTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TWSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TWSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/twsb_pkg.sv
// -----------------------------------------------------------------------------
// twsb_pkg
// Types, codes and sequence tables shared by the two-wire sensor bus master.
// -----------------------------------------------------------------------------
package twsb_pkg;

  localparam logic [4:0] PH_IDLE = 5'd31;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_TEMP     = 3'd1,
    CMD_HUM      = 3'd2,
    CMD_RD_STAT  = 3'd3,
    CMD_WR_STAT  = 3'd4,
    CMD_SOFT_RST = 3'd5,
    CMD_LINK_RST = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    OP_END   = 3'd0,
    OP_TS    = 3'd1,
    OP_CR    = 3'd2,
    OP_WCMD  = 3'd3,
    OP_WVAL  = 3'd4,
    OP_POLL  = 3'd5,
    OP_RACK  = 3'd6,
    OP_RNACK = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    REG_HALF_PERIOD   = 2'd0,
    REG_POLL_INTERVAL = 2'd1,
    REG_POLL_LIMIT    = 2'd2
  } reg_e;

  typedef struct packed {
    logic [7:0]  half_period;
    logic [23:0] poll_interval;
    logic [7:0]  poll_limit;
  } cfg_t;

  typedef struct packed {
    logic        clock_high;
    logic        data_release;
    logic        busy;
    logic        done;
    logic [15:0] read_value;
    logic [7:0]  read_checksum;
    logic [1:0]  error_count;
  } res_t;

  // Step program of each command, indexed by program position.
  function automatic op_e prog_op(input logic [2:0] cmd, input logic [4:0] ph);
    op_e op;
    op = OP_END;
    if (ph[4:3] == 2'd0) begin
      case (cmd)
        CMD_TEMP, CMD_HUM: begin
          case (ph[2:0])
            3'd0: op = OP_TS;
            3'd1: op = OP_WCMD;
            3'd2: op = OP_POLL;
            3'd3: op = OP_RACK;
            3'd4: op = OP_RACK;
            3'd5: op = OP_RNACK;
            default: op = OP_END;
          endcase
        end
        CMD_RD_STAT: begin
          case (ph[2:0])
            3'd0: op = OP_TS;
            3'd1: op = OP_WCMD;
            3'd2: op = OP_RACK;
            3'd3: op = OP_RNACK;
            default: op = OP_END;
          endcase
        end
        CMD_WR_STAT: begin
          case (ph[2:0])
            3'd0: op = OP_TS;
            3'd1: op = OP_WCMD;
            3'd2: op = OP_WVAL;
            default: op = OP_END;
          endcase
        end
        CMD_SOFT_RST: begin
          case (ph[2:0])
            3'd0: op = OP_CR;
            3'd1: op = OP_TS;
            3'd2: op = OP_WCMD;
            default: op = OP_END;
          endcase
        end
        CMD_LINK_RST: begin
          case (ph[2:0])
            3'd0: op = OP_CR;
            3'd1: op = OP_TS;
            default: op = OP_END;
          endcase
        end
        default: op = OP_END;
      endcase
    end
    return op;
  endfunction

  // Command byte sent on the bus for each command.
  function automatic logic [7:0] cmd_code(input logic [2:0] cmd);
    logic [7:0] code;
    code = 8'h00;
    case (cmd)
      CMD_TEMP:     code = 8'h03;
      CMD_HUM:      code = 8'h05;
      CMD_RD_STAT:  code = 8'h07;
      CMD_WR_STAT:  code = 8'h06;
      CMD_SOFT_RST: code = 8'h1E;
      default:      code = 8'h00;
    endcase
    return code;
  endfunction

  // Transmission start: SCK, DATA and length in half periods per step.
  function automatic logic start_clk(input logic [2:0] s);
    logic v;
    case (s)
      3'd0:    v = 1'b0;
      3'd1:    v = 1'b1;
      3'd2:    v = 1'b1;
      3'd3:    v = 1'b0;
      default: v = 1'b1;
    endcase
    return v;
  endfunction

  function automatic logic start_dat(input logic [2:0] s);
    logic v;
    case (s)
      3'd0:    v = 1'b1;
      3'd1:    v = 1'b1;
      3'd2:    v = 1'b0;
      3'd3:    v = 1'b0;
      3'd4:    v = 1'b0;
      default: v = 1'b1;
    endcase
    return v;
  endfunction

  function automatic logic start_double(input logic [2:0] s);
    return (s == 3'd3);
  endfunction

endpackage

// File: src/twsb_cfg_regs.sv
// -----------------------------------------------------------------------------
// twsb_cfg_regs
// Configuration registers of the two-wire sensor bus master.
// -----------------------------------------------------------------------------
module twsb_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [23:0]         cfg_data_i,
  output twsb_pkg::cfg_t      cfg_o
);
  import twsb_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_HALF_PERIOD:   cfg_d.half_period   = cfg_data_i[7:0];
        REG_POLL_INTERVAL: cfg_d.poll_interval = cfg_data_i;
        REG_POLL_LIMIT:    cfg_d.poll_limit    = cfg_data_i[7:0];
        default:           cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period   <= 8'd8;
      cfg_q.poll_interval <= 24'd400000;
      cfg_q.poll_limit    <= 8'd50;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: src/twsb_seq.sv
// -----------------------------------------------------------------------------
// twsb_seq
// Bus sequencer: advances by one tick for each processed item and computes
// the line levels, status and read data that the tick leaves behind.
// -----------------------------------------------------------------------------
module twsb_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [2:0]          cmd_i,
  input  logic [7:0]          status_value_i,
  input  logic                data_line_in_i,
  input  twsb_pkg::cfg_t      cfg_i,
  output twsb_pkg::res_t      res_o
);
  import twsb_pkg::*;

  localparam logic [4:0] SEG_LAST_TS = 5'd5;
  localparam logic [4:0] SEG_LAST    = 5'd18;
  localparam logic [4:0] SEG_ACK_CLK = 5'd17;
  localparam logic [4:0] SEG_ACK_END = 5'd18;
  localparam logic [4:0] SEG_BYTE    = 5'd16;

  logic [4:0]  phase_q, phase_d;
  logic [2:0]  cmd_q, cmd_d;
  logic [23:0] tick_q, tick_d;
  logic [4:0]  seg_q, seg_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  pend_q, pend_d;
  logic [15:0] value_q, value_d;
  logic [7:0]  chk_q, chk_d;
  logic [7:0]  poll_q, poll_d;
  logic [1:0]  err_q, err_d;
  logic        clk_q, clk_d;
  logic        dat_q, dat_d;
  logic        done;

  always_comb begin
    logic [4:0]  ph;
    logic [4:0]  s;
    logic        run;
    logic        do_step;
    logic        err_inc;
    logic [7:0]  h_eff;
    logic [23:0] pi_eff;
    logic [7:0]  wbyte;
    op_e         op;

    phase_d = phase_q;
    cmd_d   = cmd_q;
    tick_d  = tick_q;
    seg_d   = seg_q;
    shift_d = shift_q;
    pend_d  = pend_q;
    value_d = value_q;
    chk_d   = chk_q;
    poll_d  = poll_q;
    err_d   = err_q;
    clk_d   = clk_q;
    dat_d   = dat_q;
    done    = 1'b0;

    ph      = phase_q;
    s       = seg_q;
    run     = 1'b0;
    do_step = 1'b0;
    err_inc = 1'b0;
    h_eff   = (cfg_i.half_period == 8'd0) ? 8'd1 : cfg_i.half_period;
    pi_eff  = (cfg_i.poll_interval == 24'd0) ? 24'd1 : cfg_i.poll_interval;
    wbyte   = 8'd0;
    op      = OP_END;

    if (fire_i) begin
      if (phase_q == PH_IDLE) begin
        if (cmd_i inside {CMD_TEMP, CMD_HUM, CMD_RD_STAT, CMD_WR_STAT,
                          CMD_SOFT_RST, CMD_LINK_RST}) begin
          cmd_d  = cmd_i;
          pend_d = status_value_i;
          err_d  = 2'd0;
          poll_d = 8'd0;
          if (cmd_i inside {CMD_TEMP, CMD_HUM, CMD_RD_STAT}) begin
            value_d = 16'd0;
            chk_d   = 8'd0;
          end
          ph  = 5'd0;
          s   = 5'd0;
          run = 1'b1;
        end
      end else if (tick_q != 24'd0) begin
        tick_d = tick_q - 24'd1;
      end else begin
        op = prog_op(cmd_q, phase_q);
        if (op != OP_POLL) begin
          if (s < ((op == OP_TS) ? SEG_LAST_TS : SEG_LAST)) begin
            s = s + 5'd1;
          end else begin
            ph = ph + 5'd1;
            s  = 5'd0;
          end
        end
        run = 1'b1;
      end
    end

    if (run) begin
      op      = prog_op(cmd_d, ph);
      do_step = 1'b1;
      if (op == OP_POLL) begin
        clk_d = 1'b0;
        dat_d = 1'b1;
        if (!data_line_in_i || (poll_d >= cfg_i.poll_limit)) begin
          // Sensor ready or polls used up: the first read starts in this tick.
          err_inc = data_line_in_i;
          poll_d  = 8'd0;
          ph      = ph + 5'd1;
          s       = 5'd0;
          op      = prog_op(cmd_d, ph);
        end else begin
          poll_d  = poll_d + 8'd1;
          tick_d  = pi_eff - 24'd1;
          do_step = 1'b0;
        end
      end

      if (do_step) begin
        clk_d  = 1'b0;
        dat_d  = 1'b1;
        tick_d = {16'd0, h_eff - 8'd1};
        case (op)
          OP_END: begin
            ph     = PH_IDLE;
            done   = 1'b1;
            tick_d = tick_q;
          end
          OP_TS: begin
            clk_d = start_clk(s[2:0]);
            dat_d = start_dat(s[2:0]);
            if (start_double(s[2:0])) begin
              tick_d = {15'd0, {h_eff, 1'b0} - 9'd1};
            end
          end
          OP_CR: begin
            clk_d = s[0];
          end
          OP_WCMD, OP_WVAL: begin
            wbyte = (op == OP_WCMD) ? cmd_code(cmd_d) : pend_d;
            if (s < SEG_BYTE) begin
              dat_d = wbyte[3'd7 - s[3:1]];
              clk_d = s[0];
            end else begin
              clk_d   = (s == SEG_ACK_CLK);
              err_inc = (s == SEG_ACK_END) && data_line_in_i;
            end
          end
          default: begin
            // Byte read; the acknowledge level depends on whether more follow.
            if (s == 5'd0) begin
              shift_d = 8'd0;
            end
            if (s < SEG_BYTE) begin
              clk_d = ~s[0];
              if (s[0] && data_line_in_i) begin
                shift_d[3'd7 - s[3:1]] = 1'b1;
              end
            end else begin
              if (s == SEG_BYTE) begin
                if (op == OP_RNACK) begin
                  chk_d = shift_d;
                end else begin
                  value_d = {value_d[7:0], shift_d};
                end
              end
              clk_d = (s == SEG_BYTE);
              dat_d = (s == SEG_ACK_END) ? 1'b1 : (op == OP_RNACK);
            end
          end
        endcase
      end

      if (err_inc && (err_d != 2'd3)) begin
        err_d = err_d + 2'd1;
      end
      phase_d = ph;
      seg_d   = s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cmd_q   <= CMD_NONE;
      tick_q  <= 24'd0;
      seg_q   <= 5'd0;
      shift_q <= 8'd0;
      pend_q  <= 8'd0;
      value_q <= 16'd0;
      chk_q   <= 8'd0;
      poll_q  <= 8'd0;
      err_q   <= 2'd0;
      clk_q   <= 1'b1;
      dat_q   <= 1'b1;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      tick_q  <= tick_d;
      seg_q   <= seg_d;
      shift_q <= shift_d;
      pend_q  <= pend_d;
      value_q <= value_d;
      chk_q   <= chk_d;
      poll_q  <= poll_d;
      err_q   <= err_d;
      clk_q   <= clk_d;
      dat_q   <= dat_d;
    end
  end

  assign res_o.clock_high    = clk_d;
  assign res_o.data_release  = dat_d;
  assign res_o.busy          = (phase_d != PH_IDLE);
  assign res_o.done          = done;
  assign res_o.read_value    = value_d;
  assign res_o.read_checksum = chk_d;
  assign res_o.error_count   = err_d;

endmodule

// File: src/two_wire_sensor_bus_master.sv
// -----------------------------------------------------------------------------
// two_wire_sensor_bus_master
// Tick-driven master for a two-wire humidity/temperature sensor bus.
// -----------------------------------------------------------------------------
// Each input item is one bus tick. It carries the sampled DATA level and, while
// the block is idle, an optional command with the status byte to write. Every
// item yields exactly one result item: SCK and DATA drive levels, busy, a
// one-tick done pulse, the read value, checksum and error count.
// Items enter on in_valid_i / in_stall_o and results leave on out_valid_o /
// out_stall_i. An item is registered on entry, processed by the sequencer and
// lands in the output register, from which its result is offered. One item per
// cycle is sustained while the receiver does not stall; the rate is set by the
// single sequencer step between the input and output registers.
// When the receiver stalls, the held result stays put, one more item waits in
// the input register and then in_stall_o rises until the result is taken.
// Registers are written on cfg_valid_i / cfg_ready_o (always ready) with an
// index of 0 half period, 1 poll interval, 2 poll limit.
// Reset empties both registers, leaves the sequencer idle with both lines
// released and restores half period 8, poll interval 400000, poll limit 50.
// -----------------------------------------------------------------------------
module two_wire_sensor_bus_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  status_value_i,
  input  logic        data_line_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        clock_high_o,
  output logic        data_release_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [15:0] read_value_o,
  output logic [7:0]  read_checksum_o,
  output logic [1:0]  error_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import twsb_pkg::*;

  cfg_t       cfg;
  res_t       res;
  res_t       res_q;
  logic       in_vld_q, in_vld_d;
  logic       out_vld_q, out_vld_d;
  logic [2:0] cmd_q;
  logic [7:0] sv_q;
  logic       din_q;
  logic       fire;
  logic       in_take;

  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d  = in_take ? 1'b1 : (fire ? 1'b0 : in_vld_q);
    out_vld_d = fire ? 1'b1 : (out_stall_i ? out_vld_q : 1'b0);
  end

  twsb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  twsb_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .cmd_i          (cmd_q),
    .status_value_i (sv_q),
    .data_line_in_i (din_q),
    .cfg_i          (cfg),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= cmd_i;
      sv_q  <= status_value_i;
      din_q <= data_line_in_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign clock_high_o    = res_q.clock_high;
  assign data_release_o  = res_q.data_release;
  assign busy_res_o      = res_q.busy;
  assign done_res_o      = res_q.done;
  assign read_value_o    = res_q.read_value;
  assign read_checksum_o = res_q.read_checksum;
  assign error_count_o   = res_q.error_count;

endmodule

// File: src/twsb_checker.sv
// -----------------------------------------------------------------------------
// twsb_checker
// Port-level checks for the two-wire sensor bus master, bound to the top level.
// -----------------------------------------------------------------------------
`include "two_wire_sensor_bus_master_assert.svh"

module twsb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        clock_high_o,
  input logic        data_release_o,
  input logic        busy_res_o,
  input logic        done_res_o,
  input logic [15:0] read_value_o,
  input logic [7:0]  read_checksum_o,
  input logic [1:0]  error_count_o
);

  // A result held by the receiver must not change.
  `TWSB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(clock_high_o) && $stable(data_release_o) &&
    $stable(busy_res_o) && $stable(done_res_o) && $stable(read_value_o) &&
    $stable(read_checksum_o) && $stable(error_count_o), "stalled result changed")

  // Completion ends the sequence.
  `TWSB_ASSERT_NOW(a_done_idle, out_valid_o && done_res_o, !busy_res_o,
    "done reported while busy")

  // While idle the data line is never driven low.
  `TWSB_ASSERT_NOW(a_idle_release, out_valid_o && !busy_res_o, data_release_o,
    "data line driven while idle")

  // A completed command parks the clock low with data released.
  `TWSB_ASSERT_NOW(a_done_lines, out_valid_o && done_res_o,
    !clock_high_o && data_release_o, "lines not parked at completion")

endmodule

bind two_wire_sensor_bus_master twsb_checker u_twsb_checker (.*);

// File: sim/tb.sv
// -----------------------------------------------------------------------------
// Two-wire sensor bus master testbench
// Feeds bus ticks with commands and sampled DATA levels, tracks the sequencer
// in a local model and compares every result item field by field, with
// register changes between phases, random gaps and stalls on both sides.
// -----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import twsb_pkg::*;

  localparam logic [2:0] CMD_UNUSED     = 3'd7;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         LONG_HOLD      = 60;
  // Transmission start levels, indexed by step.
  localparam logic [5:0] SCK_START_LVL = 6'b110110;
  localparam logic [5:0] SDA_START_LVL = 6'b100011;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] status_value;
    logic       data_line;
  } tick_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i = CMD_NONE;
  logic [7:0]  status_value_i = 8'h00;
  logic        data_line_in_i = 1'b1;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        clock_high_o;
  logic        data_release_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [15:0] read_value_o;
  logic [7:0]  read_checksum_o;
  logic [1:0]  error_count_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_HALF_PERIOD;
  logic [23:0] cfg_data_i = 24'h0;

  two_wire_sensor_bus_master dut (.*);

  // Sequencer model state.
  logic [7:0]  hp_reg;
  logic [23:0] poll_ivl_reg;
  logic [7:0]  poll_lim_reg;
  logic [4:0]  seq_phase;
  logic [2:0]  seq_cmd;
  logic [23:0] ticks_left;
  logic [4:0]  seg;
  logic [7:0]  rx_byte;
  logic [7:0]  tx_value;
  logic [15:0] meas_value;
  logic [7:0]  meas_checksum;
  logic [7:0]  polls_done;
  logic [1:0]  err_total;
  logic        sck_level;
  logic        sda_level;

  tick_item_t tick_queue[$];
  tick_item_t next_tick;
  res_t       bus_tick_results[$];
  res_t       seen;
  res_t       want;

  int  ticks_queued = 0;
  int  ticks_taken = 0;
  int  fail_count = 0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  hold_requests = 0;
  int  holds_served = 0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  bit  item_taken = 1'b0;
  bit  result_taken;
  logic din_level = 1'b1;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic op_e program_step(logic [2:0] c, logic [4:0] ph);
    op_e op;
    op = OP_END;
    case (c)
      CMD_TEMP, CMD_HUM: begin
        case (ph)
          5'd0: op = OP_TS;
          5'd1: op = OP_WCMD;
          5'd2: op = OP_POLL;
          5'd3, 5'd4: op = OP_RACK;
          5'd5: op = OP_RNACK;
          default: op = OP_END;
        endcase
      end
      CMD_RD_STAT: begin
        case (ph)
          5'd0: op = OP_TS;
          5'd1: op = OP_WCMD;
          5'd2: op = OP_RACK;
          5'd3: op = OP_RNACK;
          default: op = OP_END;
        endcase
      end
      CMD_WR_STAT: begin
        case (ph)
          5'd0: op = OP_TS;
          5'd1: op = OP_WCMD;
          5'd2: op = OP_WVAL;
          default: op = OP_END;
        endcase
      end
      CMD_SOFT_RST: begin
        case (ph)
          5'd0: op = OP_CR;
          5'd1: op = OP_TS;
          5'd2: op = OP_WCMD;
          default: op = OP_END;
        endcase
      end
      CMD_LINK_RST: begin
        case (ph)
          5'd0: op = OP_CR;
          5'd1: op = OP_TS;
          default: op = OP_END;
        endcase
      end
      default: op = OP_END;
    endcase
    return op;
  endfunction

  function automatic logic [7:0] command_byte(logic [2:0] c);
    case (c)
      CMD_TEMP:     return 8'h03;
      CMD_HUM:      return 8'h05;
      CMD_RD_STAT:  return 8'h07;
      CMD_WR_STAT:  return 8'h06;
      CMD_SOFT_RST: return 8'h1E;
      default:      return 8'h00;
    endcase
  endfunction

  function automatic void add_error();
    if (err_total != 2'd3) err_total++;
  endfunction

  // Starts the step at the current program position; returns 1 on completion.
  function automatic bit launch_step(logic din);
    op_e        op;
    logic [4:0] s;
    logic       c;
    logic       d;
    logic [7:0] b;
    int         halves;
    int         h;
    while (1'b1) begin
      op = program_step(seq_cmd, seq_phase);
      s = seg;
      c = 1'b0;
      d = 1'b1;
      halves = 1;
      if (op == OP_END) begin
        seq_phase = PH_IDLE;
        sck_level = 1'b0;
        sda_level = 1'b1;
        return 1'b1;
      end
      if (op == OP_POLL) begin
        sck_level = 1'b0;
        sda_level = 1'b1;
        // A low DATA level or an exhausted poll budget moves on to the reads.
        if (din == 1'b0 || polls_done >= poll_lim_reg) begin
          if (din) add_error();
          polls_done = 8'd0;
          seq_phase++;
          seg = 5'd0;
          continue;
        end
        polls_done++;
        ticks_left = (poll_ivl_reg == 24'd0) ? 24'd0 : poll_ivl_reg - 24'd1;
        return 1'b0;
      end
      case (op)
        OP_TS: begin
          if (s > 5'd5) s = 5'd5;
          c = SCK_START_LVL[s];
          d = SDA_START_LVL[s];
          if (s == 5'd3) halves = 2;
        end
        OP_CR: c = s[0];
        OP_WCMD, OP_WVAL: begin
          b = (op == OP_WCMD) ? command_byte(seq_cmd) : tx_value;
          if (s < 5'd16) begin
            d = b[7 - s[3:1]];
            c = s[0];
          end else begin
            c = (s == 5'd17);
            if (s == 5'd18 && din) add_error();
          end
        end
        default: begin
          if (s == 5'd0) rx_byte = 8'h00;
          if (s < 5'd16) begin
            c = ~s[0];
            if (s[0] && din) rx_byte[7 - s[3:1]] = 1'b1;
          end else begin
            if (s == 5'd16) begin
              if (op == OP_RNACK) meas_checksum = rx_byte;
              else meas_value = {meas_value[7:0], rx_byte};
            end
            c = (s == 5'd16);
            d = (s == 5'd18) ? 1'b1 : (op == OP_RNACK);
          end
        end
      endcase
      sck_level = c;
      sda_level = d;
      h = (hp_reg == 8'd0) ? 1 : int'(hp_reg);
      ticks_left = 24'(halves * h - 1);
      return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic res_t sequence_tick(logic [2:0] c, logic [7:0] sv, logic din);
    res_t r;
    bit   fin;
    op_e  op;
    fin = 1'b0;
    if (seq_phase == PH_IDLE) begin
      if (c != CMD_NONE && c != CMD_UNUSED) begin
        seq_cmd = c;
        tx_value = sv;
        err_total = 2'd0;
        polls_done = 8'd0;
        if (c <= CMD_RD_STAT) begin
          meas_value = 16'h0;
          meas_checksum = 8'h0;
        end
        seq_phase = 5'd0;
        seg = 5'd0;
        fin = launch_step(din);
      end
    end else if (ticks_left > 24'd0) begin
      ticks_left--;
    end else begin
      op = program_step(seq_cmd, seq_phase);
      if (op != OP_POLL) begin
        if (seg < ((op == OP_TS) ? 5'd5 : 5'd18)) begin
          seg++;
        end else begin
          seq_phase++;
          seg = 5'd0;
        end
      end
      fin = launch_step(din);
    end
    r.clock_high = sck_level;
    r.data_release = sda_level;
    r.busy = (seq_phase != PH_IDLE);
    r.done = fin;
    r.read_value = meas_value;
    r.read_checksum = meas_checksum;
    r.error_count = err_total;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Input side: an item is held until taken, gaps are chosen at random.
  always @(negedge clk_i) begin
    if (!in_valid_i || item_taken) begin
      if (rst_ni && tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_tick = tick_queue.pop_front();
        in_valid_i <= 1'b1;
        cmd_i <= next_tick.cmd;
        status_value_i <= next_tick.status_value;
        data_line_in_i <= next_tick.data_line;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side stalls, including the occasional long hold-off.
  always @(negedge clk_i) begin
    if (hold_left == 0 && hold_requests != holds_served) begin
      hold_left = LONG_HOLD;
      holds_served++;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    item_taken = rst_ni && in_valid_i && !in_stall_o;
    if (item_taken) begin
      bus_tick_results.push_back(sequence_tick(cmd_i, status_value_i, data_line_in_i));
      ticks_taken++;
    end
    result_taken = rst_ni && out_valid_o && !out_stall_i;
    if (result_taken) begin
      seen.clock_high = clock_high_o;
      seen.data_release = data_release_o;
      seen.busy = busy_res_o;
      seen.done = done_res_o;
      seen.read_value = read_value_o;
      seen.read_checksum = read_checksum_o;
      seen.error_count = error_count_o;
      if (bus_tick_results.size() == 0) begin
        $display("%0t: result item with none expected, expected none, got %h", $time, seen);
        fail_count++;
      end else begin
        want = bus_tick_results.pop_front();
        check_field("clock_high", 16'(want.clock_high), 16'(seen.clock_high));
        check_field("data_release", 16'(want.data_release), 16'(seen.data_release));
        check_field("busy_res", 16'(want.busy), 16'(seen.busy));
        check_field("done_res", 16'(want.done), 16'(seen.done));
        check_field("read_value", want.read_value, seen.read_value);
        check_field("read_checksum", 16'(want.read_checksum), 16'(seen.read_checksum));
        check_field("error_count", 16'(want.error_count), 16'(seen.error_count));
      end
    end
    if (item_taken || result_taken || (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_drained();
    while (ticks_taken != ticks_queued || bus_tick_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(reg_e idx, logic [23:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_HALF_PERIOD:   hp_reg = value[7:0];
      REG_POLL_INTERVAL: poll_ivl_reg = value;
      REG_POLL_LIMIT:    poll_lim_reg = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // The 8-bit registers get random upper bits, which the block drops.
  task automatic set_timing(int hp, int ivl, int lim);
    wait_drained();
    write_register(REG_HALF_PERIOD, {16'($urandom), 8'(hp)});
    write_register(REG_POLL_INTERVAL, 24'(ivl));
    write_register(REG_POLL_LIMIT, {16'($urandom), 8'(lim)});
  endtask

  // One command item followed by filler ticks at a fixed DATA level.
  task automatic queue_command(logic [2:0] first, logic [2:0] filler, logic [7:0] sv,
                               logic din, int count);
    tick_item_t t;
    t.status_value = sv;
    t.data_line = din;
    for (int i = 0; i < count; i++) begin
      t.cmd = (i == 0) ? first : filler;
      tick_queue.push_back(t);
      ticks_queued++;
    end
  endtask

  // DATA moves in runs so that polls sometimes time out and acks go both ways.
  task automatic queue_random_ticks(int count);
    tick_item_t t;
    repeat (count) begin
      if ($urandom_range(5) == 0) din_level = ~din_level;
      t.cmd = ($urandom_range(3) == 0) ? 3'($urandom_range(1, 7)) : CMD_NONE;
      t.status_value = 8'($urandom);
      t.data_line = din_level;
      tick_queue.push_back(t);
      ticks_queued++;
    end
  endtask

  task automatic run_phase(int hp, int ivl, int lim, int send_pct, int stall_p,
                           bit long_hold, int count);
    set_timing(hp, ivl, lim);
    send_idle_pct = send_pct;
    stall_pct = stall_p;
    if (long_hold) hold_requests++;
    queue_random_ticks(count);
  endtask

  initial begin
    hp_reg = 8'd8;
    poll_ivl_reg = 24'd400000;
    poll_lim_reg = 8'd50;
    seq_phase = PH_IDLE;
    seq_cmd = CMD_NONE;
    ticks_left = 24'd0;
    seg = 5'd0;
    rx_byte = 8'h00;
    tx_value = 8'h00;
    meas_value = 16'h0;
    meas_checksum = 8'h00;
    polls_done = 8'd0;
    err_total = 2'd0;
    sck_level = 1'b1;
    sda_level = 1'b1;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed commands: the first one runs on the reset timing.
    queue_command(CMD_LINK_RST, CMD_NONE, 8'h00, 1'b1, 220);
    set_timing(1, 2, 2);
    queue_command(CMD_TEMP, CMD_NONE, 8'h00, 1'b0, 100);
    queue_command(CMD_HUM, CMD_NONE, 8'hFF, 1'b1, 100);
    queue_command(CMD_RD_STAT, CMD_NONE, 8'h00, 1'b1, 75);
    queue_command(CMD_RD_STAT, CMD_NONE, 8'hFF, 1'b0, 75);
    queue_command(CMD_WR_STAT, CMD_NONE, 8'hA5, 1'b0, 50);
    queue_command(CMD_WR_STAT, CMD_NONE, 8'h5A, 1'b1, 50);
    queue_command(CMD_SOFT_RST, CMD_NONE, 8'h00, 1'b0, 60);
    queue_command(CMD_LINK_RST, CMD_NONE, 8'h00, 1'b1, 40);
    queue_command(CMD_UNUSED, CMD_UNUSED, 8'h3C, 1'b0, 3);
    // Commands offered on every tick of a running measurement are dropped.
    queue_command(CMD_TEMP, CMD_HUM, 8'hC3, 1'b0, 100);

    run_phase(1, 1, 3, 0, 0, 1'b0, 120);
    run_phase(0, 0, 0, 62, 0, 1'b0, 100);
    run_phase(2, 3, 255, 0, 62, 1'b0, 110);
    run_phase(3, 24'hFFFFFF, 0, 32, 32, 1'b0, 100);
    run_phase(255, 5, 2, 0, 0, 1'b0, 80);
    // Timing changes under a step that is still counting down.
    run_phase(1, 2, 1, 32, 32, 1'b1, 120);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (bus_tick_results.size() != 0) begin
      $display("%0t: %0d result items never arrived", $time, bus_tick_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/twsb_pkg.sv
src/twsb_cfg_regs.sv
src/twsb_seq.sv
src/two_wire_sensor_bus_master.sv
src/twsb_checker.sv
sim/tb.sv
